// ===== rtl/cls_pkg.sv =====
// Shared types, codes and helpers for the command line splitter.
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

  // Default bounds
  localparam int unsigned MAX_RUN   = 32;
  localparam int unsigned MAX_ARGS  = 255;
  localparam int unsigned MAX_CHARS = 65535;

  // Backslash run counter width (covers MAX_RUN up to 63)
  localparam int unsigned RunW = 6;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h5C;

  // Result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END_ARG  = 2'd1;
  localparam logic [1:0] KIND_END_LINE = 2'd2;

  typedef enum logic [4:0] {
    PH_LEAD    = 5'b00001,
    PH_PQUOTED = 5'b00010,
    PH_PPLAIN  = 5'b00100,
    PH_BETWEEN = 5'b01000,
    PH_ARG     = 5'b10000
  } phase_e;

  typedef enum logic [4:0] {
    SEQ_IDLE  = 5'b00001,
    SEQ_SLASH = 5'b00010,
    SEQ_BYTE  = 5'b00100,
    SEQ_EARG  = 5'b01000,
    SEQ_ELINE = 5'b10000
  } seq_e;

  // Parser state carried between bytes
  typedef struct packed {
    phase_e          phase;
    logic            in_quote;
    logic            pend_quote;
    logic [RunW-1:0] slash_run;
  } pstate_t;

  // What one byte asks the sequencer to emit, in this order:
  // backslashes, one byte, end of argument, end of line.
  typedef struct packed {
    logic [RunW-1:0] n_slash;
    logic            emit_byte;
    logic [7:0]      byte_val;
    logic            end_arg;
    logic            end_line;
    logic            arg_inc;
    logic            ov_set;
  } plan_t;

  localparam pstate_t PST_RESET = '{
    phase:      PH_LEAD,
    in_quote:   1'b0,
    pend_quote: 1'b0,
    slash_run:  '0
  };

  function automatic seq_e first_step(logic slashes, logic byte_f, logic earg, logic eline);
    seq_e s;
    if (slashes) begin
      s = SEQ_SLASH;
    end else if (byte_f) begin
      s = SEQ_BYTE;
    end else if (earg) begin
      s = SEQ_EARG;
    end else if (eline) begin
      s = SEQ_ELINE;
    end else begin
      s = SEQ_IDLE;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cls_decode.sv =====
// Per-byte parser: next parser state and the emission plan for one byte.
`timescale 1ns / 1ps
`default_nettype none

module cls_decode
  import cls_pkg::*;
#(
  parameter int unsigned MaxRun = MAX_RUN
) (
  input  pstate_t    st_i,
  input  logic [7:0] char_i,
  output pstate_t    st_o,
  output plan_t      plan_o
);

  pstate_t         nst;
  plan_t           pl;
  logic            blank;
  logic            is_nul;
  logic            is_quote;
  logic            plain;
  logic            do_arg;
  logic            pend_hit;
  logic            iq;
  logic            pq;
  logic [RunW-1:0] run;

  assign blank    = (char_i == CH_SPACE) || (char_i == CH_TAB);
  assign is_nul   = (char_i == CH_NUL);
  assign is_quote = (char_i == CH_QUOTE);

  always_comb begin
    nst    = st_i;
    pl     = '0;
    plain  = 1'b0;
    do_arg = 1'b0;
    iq     = st_i.in_quote;
    pq     = st_i.pend_quote;
    run    = st_i.slash_run;

    case (st_i.phase)
      PH_LEAD: begin
        if (!blank) begin
          if (is_quote) begin
            nst.phase = PH_PQUOTED;
          end else begin
            plain = 1'b1;
          end
        end
      end
      PH_PQUOTED: begin
        if (is_nul) begin
          pl.end_arg  = 1'b1;
          pl.end_line = 1'b1;
        end else if (is_quote) begin
          pl.end_arg = 1'b1;
          nst.phase  = PH_BETWEEN;
        end else begin
          pl.emit_byte = 1'b1;
          pl.byte_val  = char_i;
        end
      end
      PH_PPLAIN: begin
        plain = 1'b1;
      end
      PH_BETWEEN: begin
        if (!blank) begin
          if (is_nul) begin
            pl.end_line = 1'b1;
          end else begin
            pl.arg_inc = 1'b1;
            iq         = 1'b0;
            pq         = 1'b0;
            run        = '0;
            nst.phase  = PH_ARG;
            do_arg     = 1'b1;
          end
        end
      end
      PH_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        nst = PST_RESET;
      end
    endcase

    // program name without quotes: copied literally up to a blank or the terminator
    if (plain) begin
      if (is_nul) begin
        pl.end_arg  = 1'b1;
        pl.end_line = 1'b1;
      end else if (blank) begin
        pl.end_arg = 1'b1;
        nst.phase  = PH_BETWEEN;
      end else begin
        pl.emit_byte = 1'b1;
        pl.byte_val  = char_i;
        nst.phase    = PH_PPLAIN;
      end
    end

    pend_hit = pq && is_quote;
    if (do_arg) begin
      if (pq) begin
        pq = 1'b0;
        iq = 1'b0;
      end
      if (pend_hit) begin
        // doubled quote inside quotes
        pl.emit_byte = 1'b1;
        pl.byte_val  = CH_QUOTE;
      end else if (char_i == CH_SLASH) begin
        if (run < RunW'(MaxRun)) begin
          run = run + RunW'(1);
        end else begin
          pl.ov_set = 1'b1;
        end
      end else if (is_quote) begin
        pl.n_slash = run >> 1;
        if (run[0]) begin
          pl.emit_byte = 1'b1;
          pl.byte_val  = CH_QUOTE;
        end else if (iq) begin
          pq = 1'b1;
        end else begin
          iq = 1'b1;
        end
        run = '0;
      end else begin
        pl.n_slash = run;
        run        = '0;
        if (is_nul) begin
          pl.end_arg  = 1'b1;
          pl.end_line = 1'b1;
        end else if (!iq && blank) begin
          pl.end_arg = 1'b1;
          nst.phase  = PH_BETWEEN;
        end else begin
          pl.emit_byte = 1'b1;
          pl.byte_val  = char_i;
        end
      end
      nst.in_quote   = iq;
      nst.pend_quote = pq;
      nst.slash_run  = run;
    end

    if (pl.end_line) begin
      nst = PST_RESET;
    end
  end

  assign st_o   = nst;
  assign plan_o = pl;

endmodule

`default_nettype wire

// ===== rtl/command_line_splitter_unit.sv =====
// Top level of the command line splitter: parser state, output sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

// Splits a zero-terminated command line, one byte per request, into arguments
// under the Windows C runtime rules. When a byte is taken, the parser decides
// what it causes: a run of backslashes, one argument byte, an end-of-argument
// mark and an end-of-line item, in that order. A small sequencer then sends
// those results one per cycle, while the output is not stalled, through the
// output register; the backslash run is flushed by a down counter, one
// backslash a cycle (a flush holds at most MAX_RUN/2 or MAX_RUN backslashes).
// No new byte is taken until the last result of the previous one has been
// loaded: in_stall_o stays high until then. A byte with no result (skipped
// blank, opening quote, backslash) leaves the sequencer idle. The
// end-of-line result carries the argument count (program name included) and
// the character count (terminators included), both saturating, and the
// backslash-overflow flag; last_o marks the final result of each input byte.
// After an end of line all state is back at reset and the next byte starts a
// new line.
module command_line_splitter_unit
  import cls_pkg::*;
#(
  parameter int unsigned MaxRun   = MAX_RUN,
  parameter int unsigned MaxArgs  = MAX_ARGS,
  parameter int unsigned MaxChars = MAX_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  arg_count_o,
  output logic [15:0] char_count_o,
  output logic        run_overflow_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(MaxArgs + 1);
  localparam int unsigned CW = $clog2(MaxChars + 1);

  // parser
  pstate_t pst_q;
  pstate_t pst_d;
  plan_t   plan;

  cls_decode #(
    .MaxRun(MaxRun)
  ) u_decode (
    .st_i  (pst_q),
    .char_i(in_char_i),
    .st_o  (pst_d),
    .plan_o(plan)
  );

  // line counters
  logic [AW-1:0] args_q;
  logic [CW-1:0] chars_q;
  logic          ovs_q;
  logic [AW-1:0] ac_full;

  // sequencer
  seq_e            seq_q;
  seq_e            seq_after;
  seq_e            seq_first;
  logic [RunW-1:0] cnt_q;
  logic [RunW-1:0] cnt_after;
  logic            byte_f_q;
  logic            earg_f_q;
  logic            eline_f_q;
  logic            byte_after;
  logic            earg_after;
  logic            eline_after;
  logic [7:0]      byte_q;
  logic [7:0]      ac_q;
  logic            ov_q;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_ac_q;
  logic [15:0] out_cc_q;
  logic        out_ov_q;
  logic        out_last_q;

  logic        accept;
  logic        load;
  logic [7:0]  item_char;
  logic [1:0]  item_kind;
  logic        item_eol;
  logic [AW+7:0]  ac_ext;
  logic [CW+15:0] cc_ext;

  assign in_stall_o = (seq_q != SEQ_IDLE);
  assign accept     = in_valid_i && (seq_q == SEQ_IDLE);
  assign load       = (seq_q != SEQ_IDLE) && (!out_valid_q || !out_stall_i);

  // program name counts as one more argument
  assign ac_full = (args_q >= AW'(MaxArgs)) ? AW'(MaxArgs) : args_q + AW'(1);
  assign ac_ext  = {8'b0, ac_full};
  assign cc_ext  = {16'b0, chars_q};

  assign seq_first = first_step(plan.n_slash != '0, plan.emit_byte, plan.end_arg,
                                plan.end_line);

  // what is left after the current step goes out
  always_comb begin
    cnt_after   = cnt_q;
    byte_after  = byte_f_q;
    earg_after  = earg_f_q;
    eline_after = eline_f_q;
    item_char   = 8'h00;
    item_kind   = KIND_BYTE;
    item_eol    = 1'b0;
    case (seq_q)
      SEQ_SLASH: begin
        cnt_after = cnt_q - RunW'(1);
        item_char = CH_SLASH;
      end
      SEQ_BYTE: begin
        byte_after = 1'b0;
        item_char  = byte_q;
      end
      SEQ_EARG: begin
        earg_after = 1'b0;
        item_kind  = KIND_END_ARG;
      end
      SEQ_ELINE: begin
        eline_after = 1'b0;
        item_kind   = KIND_END_LINE;
        item_eol    = 1'b1;
      end
      default: begin
        item_char = 8'h00;
      end
    endcase
    seq_after = first_step(cnt_after != '0, byte_after, earg_after, eline_after);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q     <= PST_RESET;
      args_q    <= '0;
      chars_q   <= '0;
      ovs_q     <= 1'b0;
      seq_q     <= SEQ_IDLE;
      cnt_q     <= '0;
      byte_f_q  <= 1'b0;
      earg_f_q  <= 1'b0;
      eline_f_q <= 1'b0;
    end else begin
      if (accept) begin
        pst_q     <= pst_d;
        seq_q     <= seq_first;
        cnt_q     <= plan.n_slash;
        byte_f_q  <= plan.emit_byte;
        earg_f_q  <= plan.end_arg;
        eline_f_q <= plan.end_line;
        if (plan.end_line) begin
          args_q <= '0;
          ovs_q  <= 1'b0;
        end else begin
          if (plan.arg_inc && (args_q < AW'(MaxArgs))) begin
            args_q <= args_q + AW'(1);
          end
          if (plan.ov_set) begin
            ovs_q <= 1'b1;
          end
        end
      end else if (load) begin
        seq_q     <= seq_after;
        cnt_q     <= cnt_after;
        byte_f_q  <= byte_after;
        earg_f_q  <= earg_after;
        eline_f_q <= eline_after;
        if (item_eol) begin
          chars_q <= '0;
        end else if (chars_q < CW'(MaxChars)) begin
          chars_q <= chars_q + CW'(1);
        end
      end
    end
  end

  // payload captured with the plan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= plan.byte_val;
      ac_q   <= ac_ext[7:0];
      ov_q   <= ovs_q | plan.ov_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= item_char;
      out_kind_q <= item_kind;
      out_ac_q   <= item_eol ? ac_q : 8'h00;
      out_cc_q   <= item_eol ? cc_ext[15:0] : 16'h0000;
      out_ov_q   <= item_eol && ov_q;
      out_last_q <= (seq_after == SEQ_IDLE);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_kind_o     = out_kind_q;
  assign arg_count_o    = out_ac_q;
  assign char_count_o   = out_cc_q;
  assign run_overflow_o = out_ov_q;
  assign last_o         = out_last_q;

  // checks
  a_seq_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(seq_q))
    else $error("sequencer state not one-hot");

  a_slash_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_SLASH) |-> (cnt_q != '0))
    else $error("backslash flush with empty count");

  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_END_LINE)) |-> last_o)
    else $error("end of line not marked last");

  a_chars_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (seq_q == SEQ_ELINE)) |=> (chars_q == '0))
    else $error("char count not cleared after end of line");

  a_eol_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && plan.end_line) |=> (pst_q == PST_RESET) && (args_q == '0))
    else $error("parser not reset at end of line");

endmodule

`default_nettype wire
